### hdl/dsr_pkg.sv
// ----------------------------------------------------------------------------
// dsr_pkg
// Shared types, codes and defaults for the divisor-sum-over-range block.
// ----------------------------------------------------------------------------
`default_nettype none

package dsr_pkg;

    // Field widths of the channel payloads
    localparam int FIELD_BITS = 40;
    localparam int TOTAL_BITS = 63;

    // Parameter defaults
    localparam int VALUE_BITS_DEF = 40;
    localparam int SUM_BITS_DEF   = 63;

    // Status codes
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_SAT   = 2'd1;
    localparam logic [1:0] STATUS_ORDER = 2'd2;

    typedef struct packed {
        logic [FIELD_BITS-1:0] lower_bound;
        logic [FIELD_BITS-1:0] upper_bound;
    } req_t;

    typedef struct packed {
        logic [TOTAL_BITS-1:0] divisor_total;
        logic [1:0]            status;
    } rsp_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic div_start;
        logic mul_start;
        logic add_cnt;
        logic add_ser;
        logic step;
        logic out_load;
    } dsr_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic order_err;
        logic sq_le_hi;
        logic div_busy;
        logic mul_busy;
        logic sat_cnt;
        logic sat_ser;
        logic ser_skip;
    } dsr_sts_t;

endpackage

`default_nettype wire

### hdl/dsr_div.sv
// ----------------------------------------------------------------------------
// dsr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_div #(
    parameter int NW = 40,
    parameter int DW = 21
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [DW-1:0] den,
    output logic               busy,
    output logic [NW-1:0]      quo,
    output logic               rem_nz
);

    localparam int CW = $clog2(NW + 1);

    logic [NW-1:0] q_reg, q_next;
    logic [DW-1:0] r_reg, r_next;
    logic [DW-1:0] d_reg, d_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [DW:0]   trial;

    // One shift-subtract step
    always_comb
    begin
        trial     = {r_reg, q_reg[NW-1]};
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = CW'(NW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = DW'(trial - {1'b0, d_reg});
                q_next = {q_reg[NW-2:0], 1'b1};
            end
            else
            begin
                r_next = trial[DW-1:0];
                q_next = {q_reg[NW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign busy   = busy_reg;
    assign quo    = q_reg;
    assign rem_nz = (r_reg != '0);

endmodule

`default_nettype wire

### hdl/dsr_mul.sv
// ----------------------------------------------------------------------------
// dsr_mul
// Shift-add multiplier, one multiplier bit per cycle, full-width product.
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_mul #(
    parameter int W = 41
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [W-1:0] a,
    input  wire logic [W-1:0] b,
    output logic              busy,
    output logic [2*W-1:0]    prod
);

    localparam int CW = $clog2(W + 1);

    logic [2*W-1:0] acc_reg, acc_next;
    logic [2*W-1:0] a_reg, a_next;
    logic [W-1:0]   b_reg, b_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic           busy_reg, busy_next;

    // Add shifted multiplicand for each set multiplier bit
    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            acc_next  = '0;
            a_next    = {{W{1'b0}}, a};
            b_next    = b;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
                acc_next = acc_reg + a_reg;
            a_next   = {a_reg[2*W-2:0], 1'b0};
            b_next   = {1'b0, b_reg[W-1:1]};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign busy = busy_reg;
    assign prod = acc_reg;

endmodule

`default_nettype wire

### hdl/dsr_dp.sv
// ----------------------------------------------------------------------------
// dsr_dp
// Datapath: bounds, loop index, running square, dividers, multipliers and
// the saturating accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_dp #(
    parameter int VALUE_BITS = dsr_pkg::VALUE_BITS_DEF,
    parameter int SUM_BITS   = dsr_pkg::SUM_BITS_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire dsr_pkg::req_t     req,
    input  wire dsr_pkg::dsr_cmd_t cmd,
    output dsr_pkg::dsr_sts_t      sts,
    output dsr_pkg::rsp_t          rsp
);

    localparam int V   = VALUE_BITS;
    localparam int IW  = (V + 1) / 2 + 1;
    localparam int SQW = 2 * IW;
    localparam int MW  = V + 1;
    localparam int PW  = 2 * MW;
    localparam int SW  = ((PW > SUM_BITS) ? PW : SUM_BITS) + 1;
    localparam int FW  = dsr_pkg::FIELD_BITS;

    logic [V-1:0]        lo_reg, hi_reg;
    logic [IW-1:0]       i_reg;
    logic [SQW-1:0]      sq_reg;
    logic [SUM_BITS-1:0] total_reg;
    logic [1:0]          status_reg;
    dsr_pkg::rsp_t       rsp_reg;

    logic [FW+V-1:0] lo_ext, hi_ext;
    logic [V-1:0]    lo_in, hi_in;
    logic [V-1:0]    q_hi, q_lo;
    logic            lo_nz, hi_nz_unused;
    logic            div_busy_a, div_busy_b, mul_busy_a, mul_busy_b;
    logic [V:0]      ceil_lo, c_low, s_val, i_ext, e_val, n_val;
    logic [V+1:0]    t_val;
    logic [MW-1:0]   cnt_val, tt, nn;
    logic [PW-1:0]   prod_a, prod_b;
    logic [SW-1:0]   lim, sum_cnt, sum_ser;

    // Input fields taken modulo 2^VALUE_BITS
    assign lo_ext = {{V{1'b0}}, req.lower_bound};
    assign hi_ext = {{V{1'b0}}, req.upper_bound};
    assign lo_in  = lo_ext[V-1:0];
    assign hi_in  = hi_ext[V-1:0];

    // Two divisions by the loop index run side by side
    dsr_div #(.NW(V), .DW(IW)) u_div_hi (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (hi_reg),
        .den   (i_reg),
        .busy  (div_busy_a),
        .quo   (q_hi),
        .rem_nz(hi_nz_unused)
    );

    dsr_div #(.NW(V), .DW(IW)) u_div_lo (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (lo_reg),
        .den   (i_reg),
        .busy  (div_busy_b),
        .quo   (q_lo),
        .rem_nz(lo_nz)
    );

    // Count term and series term operands
    always_comb
    begin
        i_ext   = (V+1)'(i_reg);
        ceil_lo = {1'b0, q_lo} + (V+1)'(lo_nz);
        // first multiple index: i when i*i covers lo, else ceil(lo/i)
        c_low   = ((SQW+1)'(lo_reg) > (SQW+1)'(sq_reg)) ? ceil_lo : i_ext;
        cnt_val = MW'({1'b0, q_hi} + (V+1)'(1) - c_low);
        s_val   = (ceil_lo > i_ext + (V+1)'(1)) ? ceil_lo : i_ext + (V+1)'(1);
        e_val   = {1'b0, q_hi};
        n_val   = e_val - s_val + (V+1)'(1);
        t_val   = (V+2)'(s_val) + (V+2)'(e_val);
        if (!t_val[0])
        begin
            tt = t_val[V+1:1];
            nn = n_val;
        end
        else
        begin
            tt = t_val[V:0];
            nn = {1'b0, n_val[V:1]};
        end
    end

    dsr_mul #(.W(MW)) u_mul_cnt (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.mul_start),
        .a    (MW'(i_reg)),
        .b    (cnt_val),
        .busy (mul_busy_a),
        .prod (prod_a)
    );

    dsr_mul #(.W(MW)) u_mul_ser (
        .clk  (clk),
        .rst_n(rst_n),
        .start(cmd.mul_start),
        .a    (tt),
        .b    (nn),
        .busy (mul_busy_b),
        .prod (prod_b)
    );

    // Saturating accumulation
    assign lim     = SW'({SUM_BITS{1'b1}});
    assign sum_cnt = SW'(total_reg) + SW'(prod_a);
    assign sum_ser = SW'(total_reg) + SW'(prod_b);

    // Loop and accumulator registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            lo_reg     <= lo_in;
            hi_reg     <= hi_in;
            i_reg      <= IW'(1);
            sq_reg     <= SQW'(1);
            total_reg  <= '0;
            status_reg <= (lo_in > hi_in) ? dsr_pkg::STATUS_ORDER : dsr_pkg::STATUS_OK;
        end
        else
        begin
            if (cmd.add_cnt)
            begin
                if (sum_cnt > lim)
                begin
                    total_reg  <= {SUM_BITS{1'b1}};
                    status_reg <= dsr_pkg::STATUS_SAT;
                end
                else
                begin
                    total_reg <= sum_cnt[SUM_BITS-1:0];
                end
            end
            if (cmd.add_ser)
            begin
                if (sum_ser > lim)
                begin
                    total_reg  <= {SUM_BITS{1'b1}};
                    status_reg <= dsr_pkg::STATUS_SAT;
                end
                else
                begin
                    total_reg <= sum_ser[SUM_BITS-1:0];
                end
            end
            // (i+1)^2 = i^2 + 2i + 1
            if (cmd.step)
            begin
                i_reg  <= i_reg + IW'(1);
                sq_reg <= sq_reg + SQW'({i_reg, 1'b1});
            end
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg.divisor_total <= dsr_pkg::TOTAL_BITS'(total_reg);
            rsp_reg.status        <= status_reg;
        end
    end

    assign sts.order_err = (status_reg == dsr_pkg::STATUS_ORDER);
    assign sts.sq_le_hi  = (sq_reg <= SQW'(hi_reg));
    assign sts.div_busy  = div_busy_a | div_busy_b;
    assign sts.mul_busy  = mul_busy_a | mul_busy_b;
    assign sts.sat_cnt   = (sum_cnt > lim);
    assign sts.sat_ser   = (sum_ser > lim);
    assign sts.ser_skip  = (s_val > e_val);
    assign rsp           = rsp_reg;

endmodule

`default_nettype wire

### hdl/dsr_ctrl.sv
// ----------------------------------------------------------------------------
// dsr_ctrl
// Controller: sequences one loop step at a time and owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module dsr_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_stall,
    output logic                   rsp_valid,
    input  wire logic              rsp_stall,
    input  wire dsr_pkg::dsr_sts_t sts,
    output dsr_pkg::dsr_cmd_t      cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CHECK = 3'd1;
    localparam logic [2:0] ST_DIV   = 3'd2;
    localparam logic [2:0] ST_MUL   = 3'd3;
    localparam logic [2:0] ST_ADD1  = 3'd4;
    localparam logic [2:0] ST_ADD2  = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       out_free;

    assign out_free = !valid_reg || !rsp_stall;

    always_comb
    begin
        state_next = state_reg;
        valid_next = valid_reg;
        cmd        = '0;
        if (valid_reg && !rsp_stall)
            valid_next = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sts.order_err || !sts.sq_le_hi)
                    state_next = ST_DONE;
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!sts.div_busy)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_MUL;
                end
            end
            ST_MUL:
            begin
                if (!sts.mul_busy)
                    state_next = ST_ADD1;
            end
            ST_ADD1:
            begin
                cmd.add_cnt = 1'b1;
                if (sts.sat_cnt)
                    state_next = ST_DONE;
                else if (sts.ser_skip)
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_CHECK;
                end
                else
                    state_next = ST_ADD2;
            end
            ST_ADD2:
            begin
                cmd.add_ser = 1'b1;
                if (sts.sat_ser)
                    state_next = ST_DONE;
                else
                begin
                    cmd.step   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    valid_next   = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = valid_reg;

    // A result is only loaded when the output register is free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> out_free)
        else $error("result loaded over a pending transfer");

    // The walk only starts a step while i*i stays within the upper bound
    a_step_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> (sts.sq_le_hi && !sts.order_err))
        else $error("loop step started past the bound");

    // Multipliers are started only once both divisions have finished
    a_mul_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mul_start |-> !sts.div_busy)
        else $error("multiply started before division done");

endmodule

`default_nettype wire

### hdl/divisor_sum_over_range.sv
// ----------------------------------------------------------------------------
// divisor_sum_over_range
// Sum of sigma(n) over an inclusive interval, hyperbola method.
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req (lower_bound, upper_bound)
//   result  | rsp_valid | rsp_stall | rsp (divisor_total, status)
//
// One item at a time. Each loop step i = 1 .. floor(sqrt(upper)) runs two
// parallel bit-serial dividers, then two parallel shift-add multipliers,
// then the adds. Reset clears the controller; no clearing pass. A stalled
// result sits in the output register; the next item waits only to hand over
// its result.
// ----------------------------------------------------------------------------
`default_nettype none

module divisor_sum_over_range #(
    parameter int VALUE_BITS = dsr_pkg::VALUE_BITS_DEF,
    parameter int SUM_BITS   = dsr_pkg::SUM_BITS_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          req_valid,
    output logic               req_stall,
    input  wire dsr_pkg::req_t req,
    output logic               rsp_valid,
    input  wire logic          rsp_stall,
    output dsr_pkg::rsp_t      rsp
);

    dsr_pkg::dsr_cmd_t cmd;
    dsr_pkg::dsr_sts_t sts;

    dsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    dsr_dp #(.VALUE_BITS(VALUE_BITS), .SUM_BITS(SUM_BITS)) u_dp (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req),
        .cmd  (cmd),
        .sts  (sts),
        .rsp  (rsp)
    );

    // Out-of-order interval always reports a zero total
    a_order_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == dsr_pkg::STATUS_ORDER) |-> (rsp.divisor_total == '0))
        else $error("order error with nonzero total");

    // Saturation reports the limit value
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == dsr_pkg::STATUS_SAT)
            |-> (rsp.divisor_total == dsr_pkg::TOTAL_BITS'({SUM_BITS{1'b1}})))
        else $error("saturated total below limit");

    // Only defined status codes leave the block
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.status == dsr_pkg::STATUS_OK || rsp.status == dsr_pkg::STATUS_SAT
                       || rsp.status == dsr_pkg::STATUS_ORDER))
        else $error("undefined status code");

endmodule

`default_nettype wire
